// ===== rtl/core/bli_pkg.sv =====
// Shared constants and types for the breakpoint linear interpolator.
// Depends on nothing; imported by rtl/core/breakpoint_linear_interpolator.sv.
`default_nettype none

package bli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int PIDX_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int TIME_W     = 64;
	localparam int LEVEL_W    = 16;
	localparam int PROD_W     = TIME_W + LEVEL_W;
	localparam int DIV_CNT_W  = $clog2(PROD_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(32768);

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = CFG_IDX_W'(1);

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]  bp_time;
		logic [LEVEL_W-1:0] bp_level;
	} bp_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/breakpoint_linear_interpolator.sv =====
// Breakpoint table with linear interpolation between neighboring points.
// Depends on rtl/core/bli_pkg.sv (constants, breakpoint entry type).
`default_nettype none

//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  in      | in  | in_valid / in_ready   | action, point_index, point_time,
//          |     |                       | point_level, query_time
//  out     | out | out_valid / out_ready | level (one beat per query only)
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A breakpoint write is taken in IDLE and goes straight into the table. A query goes from IDLE
// to OUT when disabled or the table is empty, through RD0 at or before the first point and
// through RD0 and RDL at or after the last; otherwise it walks the segments in WALK (one
// memory read per cycle), then SEG, MUL and, unless dt reaches span, the one-bit-per-cycle
// 80-bit restoring divider (DIV, FIN). One item is in work at a time; a finished level waits
// in place while the output register is still full. No clearing pass after reset.

module breakpoint_linear_interpolator
	import bli_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire logic                  action,
	input  wire logic [5:0]            point_index,
	input  wire logic [TIME_W-1:0]     point_time,
	input  wire logic [LEVEL_W-1:0]    point_level,
	input  wire logic [TIME_W-1:0]     query_time,

	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [LEVEL_W-1:0]    level,

	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD0  = 4'd1;
	localparam logic [3:0] ST_RDL  = 4'd2;
	localparam logic [3:0] ST_WALK = 4'd3;
	localparam logic [3:0] ST_SEG  = 4'd4;
	localparam logic [3:0] ST_MUL  = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_FIN  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	bp_entry_t mem [MAX_POINTS];
	bp_entry_t rd_data_s1;
	logic [PIDX_W-1:0] rd_addr;
	logic              mem_we;
	logic [PIDX_W-1:0] wr_addr;
	bp_entry_t         wr_data;

	logic [3:0]           state_q;
	logic                 enable_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_W-1:0]    tq_q;
	bp_entry_t            prev_q;
	bp_entry_t            hit_q;
	logic [PIDX_W-1:0]    walk_idx_q;
	logic [TIME_W-1:0]    dt_q;
	logic [TIME_W-1:0]    span_q;
	logic [LEVEL_W-1:0]   v0_q;
	logic [LEVEL_W-1:0]   v1_q;
	logic [LEVEL_W-1:0]   mag_q;
	logic                 up_q;
	logic [PROD_W-1:0]    dvd_q;
	logic [TIME_W-1:0]    rem_q;
	logic [LEVEL_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [LEVEL_W-1:0]   res_q;
	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   level_q;

	logic [CNT_W-1:0]     n_eff;
	logic [PIDX_W-1:0]    last_idx;
	logic                 in_acc;
	logic [TIME_W:0]      rem_x;
	logic                 sub_ok;
	logic [PROD_W-1:0]    prod;
	logic                 out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign level     = level_q;

	assign n_eff    = (32'(count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : count_q;
	assign last_idx = PIDX_W'(n_eff - CNT_W'(1));

	assign mem_we  = in_acc && (action == ACT_WRITE) && (32'(point_index) < MAX_POINTS);
	assign wr_addr = PIDX_W'(point_index);
	assign wr_data = '{bp_time: point_time,
		bp_level: (point_level > LEVEL_ONE) ? LEVEL_ONE : point_level};

	always_comb begin
		unique case (state_q)
			ST_RD0:  rd_addr = last_idx;
			ST_RDL:  rd_addr = PIDX_W'(1);
			ST_WALK: rd_addr = walk_idx_q + PIDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	assign rem_x  = {rem_q, dvd_q[PROD_W-1]};
	assign sub_ok = (rem_x >= {1'b0, span_q});
	assign prod   = PROD_W'(dt_q) * PROD_W'(mag_q);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			count_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_COUNT:  count_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			level_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && action == ACT_QUERY) begin
						if (!enable_q || n_eff == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_RD0;
						end
					end
				end
				ST_RD0: begin
					if (tq_q <= rd_data_s1.bp_time) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_RDL;
					end
				end
				ST_RDL: begin
					if (tq_q >= rd_data_s1.bp_time) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (tq_q < rd_data_s1.bp_time) begin
						state_q <= ST_SEG;
					end
				end
				ST_SEG:  state_q <= ST_MUL;
				ST_MUL:  state_q <= (dt_q >= span_q) ? ST_OUT : ST_DIV;
				ST_DIV: begin
					if (div_cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				tq_q  <= query_time;
				res_q <= '0;
			end
			ST_RD0: begin
				prev_q <= rd_data_s1;
				res_q  <= rd_data_s1.bp_level;
			end
			ST_RDL: begin
				res_q      <= rd_data_s1.bp_level;
				walk_idx_q <= PIDX_W'(1);
			end
			ST_WALK: begin
				if (tq_q < rd_data_s1.bp_time) begin
					hit_q <= rd_data_s1;
				end else begin
					prev_q     <= rd_data_s1;
					walk_idx_q <= walk_idx_q + PIDX_W'(1);
				end
			end
			ST_SEG: begin
				dt_q   <= tq_q - prev_q.bp_time;
				span_q <= hit_q.bp_time - prev_q.bp_time;
				v0_q   <= prev_q.bp_level;
				v1_q   <= hit_q.bp_level;
				up_q   <= (hit_q.bp_level >= prev_q.bp_level);
				mag_q  <= (hit_q.bp_level >= prev_q.bp_level)
					? hit_q.bp_level - prev_q.bp_level
					: prev_q.bp_level - hit_q.bp_level;
			end
			ST_MUL: begin
				res_q     <= v1_q;
				dvd_q     <= prod;
				rem_q     <= '0;
				quo_q     <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				dvd_q     <= {dvd_q[PROD_W-2:0], 1'b0};
				rem_q     <= sub_ok ? TIME_W'(rem_x - {1'b0, span_q}) : rem_x[TIME_W-1:0];
				quo_q     <= {quo_q[LEVEL_W-2:0], sub_ok};
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			ST_FIN: begin
				res_q <= up_q ? v0_q + quo_q : v0_q - quo_q;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for breakpoint_linear_interpolator: directed table, then random phases.
// Expected levels come from a behavioral model of the breakpoint table kept here.
// Depends on rtl/core/bli_pkg.sv and rtl/core/breakpoint_linear_interpolator.sv.
module testbench;
	import bli_pkg::*;

	localparam int LIMIT       = 3_000_000;
	localparam int PAUSE       = 200;
	localparam int ITEM_TARGET = 900;
	localparam int N_ROWS      = 28;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
	localparam logic [TIME_W-1:0]    T_MAX       = '1;

	typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_QUERY_KNOWN, ROW_CFG} row_kind_t;

	// lvl is the point level for a write and the wanted level for a known query
	typedef struct packed {
		row_kind_t               kind;
		logic [5:0]              slot;
		logic [TIME_W-1:0]       t;
		logic [LEVEL_W-1:0]      lvl;
		logic [CFG_IDX_W-1:0]    cfg_sel;
		logic [CFG_DATA_W-1:0]   cfg_val;
	} stim_row_t;

	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{ROW_QUERY_KNOWN, 6'd0,  64'd0,                  16'd0,     REG_ENABLE,  7'd0},
		'{ROW_CFG,         6'd0,  64'd0,                  16'd0,     REG_ENABLE,  7'd1},
		'{ROW_QUERY_KNOWN, 6'd0,  T_MAX,                  16'd0,     REG_ENABLE,  7'd0},
		'{ROW_WRITE,       6'd0,  64'd100,                16'd0,     REG_ENABLE,  7'd0},
		'{ROW_WRITE,       6'd1,  64'd200,                16'hFFFF,  REG_ENABLE,  7'd0},
		'{ROW_WRITE,       6'd2,  64'd300,                16'd16384, REG_ENABLE,  7'd0},
		'{ROW_WRITE,       6'd3,  T_MAX,                  16'd12345, REG_ENABLE,  7'd0},
		'{ROW_WRITE,       6'd63, 64'h8000_0000_0000_0000, 16'h8001, REG_ENABLE,  7'd0},
		'{ROW_CFG,         6'd0,  64'd0,                  16'd0,     REG_SPARE_A, 7'h7F},
		'{ROW_CFG,         6'd0,  64'd0,                  16'd0,     REG_SPARE_B, 7'h7F},
		'{ROW_CFG,         6'd0,  64'd0,                  16'd0,     REG_COUNT,   7'd4},
		'{ROW_QUERY_KNOWN, 6'd0,  64'd0,                  16'd0,     REG_ENABLE,  7'd0},
		'{ROW_QUERY_KNOWN, 6'd0,  64'd100,                16'd0,     REG_ENABLE,  7'd0},
		'{ROW_QUERY_KNOWN, 6'd0,  64'd150,                16'd16384, REG_ENABLE,  7'd0},
		'{ROW_QUERY_KNOWN, 6'd0,  64'd250,                16'd24576, REG_ENABLE,  7'd0},
		'{ROW_QUERY,       6'd0,  64'd200,                16'd0,     REG_ENABLE,  7'd0},
		'{ROW_QUERY,       6'd0,  64'd299,                16'd0,     REG_ENABLE,  7'd0},
		'{ROW_QUERY_KNOWN, 6'd0,  T_MAX,                  16'd12345, REG_ENABLE,  7'd0},
		'{ROW_QUERY,       6'd0,  64'hFFFF_FFFF_FFFF_FFFE, 16'd0,    REG_ENABLE,  7'd0},
		'{ROW_QUERY,       6'd0,  64'd101,                16'd0,     REG_ENABLE,  7'd0},
		'{ROW_CFG,         6'd0,  64'd0,                  16'd0,     REG_COUNT,   7'd1},
		'{ROW_QUERY_KNOWN, 6'd0,  T_MAX,                  16'd0,     REG_ENABLE,  7'd0},
		'{ROW_WRITE,       6'd1,  64'd50,                 16'd500,   REG_ENABLE,  7'd0},
		'{ROW_CFG,         6'd0,  64'd0,                  16'd0,     REG_COUNT,   7'd3},
		'{ROW_QUERY_KNOWN, 6'd0,  64'd75,                 16'd0,     REG_ENABLE,  7'd0},
		'{ROW_QUERY,       6'd0,  64'd150,                16'd0,     REG_ENABLE,  7'd0},
		'{ROW_CFG,         6'd0,  64'd0,                  16'd0,     REG_ENABLE,  7'd0},
		'{ROW_QUERY_KNOWN, 6'd0,  64'd150,                16'd0,     REG_ENABLE,  7'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  action = ACT_WRITE;
	logic [5:0]            point_index = '0;
	logic [TIME_W-1:0]     point_time = '0;
	logic [LEVEL_W-1:0]    point_level = '0;
	logic [TIME_W-1:0]     query_time = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [LEVEL_W-1:0]    level;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [TIME_W-1:0]     bp_time [MAX_POINTS];
	logic [LEVEL_W-1:0]    bp_level [MAX_POINTS];
	logic                  shadow_enable = 1'b0;
	logic [CFG_DATA_W-1:0] shadow_count = '0;
	logic [LEVEL_W-1:0]    level_q [$];
	logic [LEVEL_W-1:0]    want_level;
	int                    items_sent = 0;
	int                    errors = 0;
	int                    cycles = 0;
	bit                    calm = 1'b0;

	breakpoint_linear_interpolator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.point_index(point_index),
		.point_time(point_time),
		.point_level(point_level),
		.query_time(query_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level(level),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [TIME_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int idle_cycles();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 120);
	endfunction

	function automatic logic [LEVEL_W-1:0] draw_level();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return LEVEL_ONE;
		if (r < 4)
			return LEVEL_W'($urandom);
		return LEVEL_W'($urandom_range(0, 32768));
	endfunction

	function automatic logic [TIME_W-1:0] time_step(int scale);
		case (scale)
			0: return TIME_W'($urandom_range(0, 1000));
			1: return {32'b0, $urandom};
			default: return {7'b0, 25'($urandom), $urandom};
		endcase
	endfunction

	// level at time qt from the shadow table, truncating division of the 80-bit product
	function automatic logic [LEVEL_W-1:0] predict_level(logic [TIME_W-1:0] qt);
		int n;
		logic [TIME_W-1:0]  t0, dt, span;
		logic [LEVEL_W-1:0] v0, v1, mag;
		logic [PROD_W-1:0]  quo;
		n = (shadow_count > MAX_POINTS) ? MAX_POINTS : int'(shadow_count);
		if (!shadow_enable || n == 0)
			return '0;
		if (qt <= bp_time[0])
			return bp_level[0];
		if (qt >= bp_time[n-1])
			return bp_level[n-1];
		for (int i = 1; i < n; i++) begin
			if (qt < bp_time[i]) begin
				t0 = bp_time[i-1];
				dt = qt - t0;
				span = bp_time[i] - t0;
				v0 = bp_level[i-1];
				v1 = bp_level[i];
				if (dt >= span)
					return v1;
				mag = (v1 >= v0) ? v1 - v0 : v0 - v1;
				quo = ({16'b0, dt} * {64'b0, mag}) / {16'b0, span};
				return (v1 >= v0) ? v0 + quo[LEVEL_W-1:0] : v0 - quo[LEVEL_W-1:0];
			end
		end
		return bp_level[n-1];
	endfunction

	function automatic logic [TIME_W-1:0] draw_query_time(int used);
		int r, k;
		logic [TIME_W-1:0] t0, span;
		if (used == 0)
			return rand64();
		r = $urandom_range(0, 99);
		if (r < 50 && used >= 2) begin
			k = $urandom_range(1, used - 1);
			t0 = bp_time[k-1];
			span = bp_time[k] - t0;
			if (bp_time[k] > t0)
				return t0 + rand64() % span;
			return t0;
		end
		if (r < 62)
			return bp_time[$urandom_range(0, used - 1)];
		if (r < 70)
			return ($urandom_range(0, 1) != 0) ? T_MAX : '0;
		if (r < 80)
			return ($urandom_range(0, 1) != 0) ? bp_time[0] - 1 : bp_time[used-1] + 1;
		return rand64();
	endfunction

	task automatic send_item(logic act, logic [5:0] slot, logic [TIME_W-1:0] ptime,
			logic [LEVEL_W-1:0] plevel, logic [TIME_W-1:0] qtime, bit known,
			logic [LEVEL_W-1:0] want);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		point_index <= slot;
		point_time <= ptime;
		point_level <= plevel;
		query_time <= qtime;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (act == ACT_QUERY) begin
			level_q.push_back(known ? want : predict_level(qtime));
		end else begin
			bp_time[slot] = ptime;
			bp_level[slot] = (plevel > LEVEL_ONE) ? LEVEL_ONE : plevel;
		end
	endtask

	// only while idle: all levels back, then room for a trailing write to finish
	task automatic write_register(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (level_q.size() != 0) @(posedge clk);
		repeat (PAUSE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (sel)
			REG_ENABLE: shadow_enable = val[0];
			REG_COUNT: shadow_count = val;
			default: ;
		endcase
	endtask

	task automatic run_phase();
		int sel, used, burst, scale;
		logic [CFG_DATA_W-1:0] count;
		logic [5:0] slot;
		logic [TIME_W-1:0] t;
		logic en;
		bit sorted;
		calm = ($urandom_range(0, 5) == 0);
		sel = $urandom_range(0, 9);
		case (sel)
			0: count = '0;
			1: count = CFG_DATA_W'(1);
			2: count = CFG_DATA_W'(2);
			3: count = CFG_DATA_W'(MAX_POINTS);
			4: count = CFG_DATA_W'($urandom_range(65, 127));
			default: count = CFG_DATA_W'($urandom_range(3, 12));
		endcase
		en = ($urandom_range(0, 6) != 0);
		write_register(REG_COUNT, count);
		write_register(REG_ENABLE, {6'($urandom), en});
		used = (count > MAX_POINTS) ? MAX_POINTS : int'(count);
		sorted = ($urandom_range(0, 9) != 0);
		scale = $urandom_range(0, 2);
		t = rand64() >> 2;
		for (int i = 0; i < used; i++) begin
			if (!sorted)
				t = rand64();
			else if (i > 0)
				t = t + time_step(scale);
			send_item(ACT_WRITE, 6'(i), t, draw_level(), rand64(), 1'b0, '0);
		end
		burst = $urandom_range(20, 50);
		for (int j = 0; j < burst; j++) begin
			if ($urandom_range(0, 4) == 0) begin
				slot = 6'($urandom);
				t = (slot < used && $urandom_range(0, 3) != 0) ? bp_time[slot] : rand64();
				send_item(ACT_WRITE, slot, t, draw_level(), rand64(), 1'b0, '0);
			end else begin
				send_item(ACT_QUERY, 6'($urandom), rand64(), LEVEL_W'($urandom),
					draw_query_time(used), 1'b0, '0);
			end
		end
	endtask

	initial begin
		int hold;
		forever begin
			hold = idle_cycles();
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, calm ? 50 : 8)) @(posedge clk);
		end
	end

	// result beat check against the oldest pending level
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (level_q.size() == 0) begin
				errors++;
				$display("%0t: level beat %0d with no query pending", $time, level);
			end else begin
				want_level = level_q.pop_front();
				if (level !== want_level) begin
					errors++;
					$display("%0t: level expected %0d, actual %0d", $time, want_level, level);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < N_ROWS; r++) begin
			row = DIRECTED[r];
			case (row.kind)
				ROW_WRITE:
					send_item(ACT_WRITE, row.slot, row.t, row.lvl, rand64(), 1'b0, '0);
				ROW_QUERY:
					send_item(ACT_QUERY, 6'($urandom), rand64(), LEVEL_W'($urandom),
						row.t, 1'b0, '0);
				ROW_QUERY_KNOWN:
					send_item(ACT_QUERY, 6'($urandom), rand64(), LEVEL_W'($urandom),
						row.t, 1'b1, row.lvl);
				default:
					write_register(row.cfg_sel, row.cfg_val);
			endcase
		end
		while (items_sent < ITEM_TARGET)
			run_phase();
		in_valid <= 1'b0;
		while (level_q.size() != 0) @(posedge clk);
		repeat (PAUSE) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
